// ===== rtl/qost_pkg.sv =====
package qost_pkg;

    localparam int IMG_W = 1024;
    localparam int IMG_H = 1024;
    localparam int MAX_STEPS = 64;

    localparam int PC_W = 4;
    localparam int STEP_W = 7;
    localparam int PIX_W = 26;

    localparam logic [2:0] CFG_CONST_RE = 3'd0;
    localparam logic [2:0] CFG_CONST_IM = 3'd1;
    localparam logic [2:0] CFG_LEFT     = 3'd2;
    localparam logic [2:0] CFG_TOP      = 3'd3;
    localparam logic [2:0] CFG_X_SCALE  = 3'd4;
    localparam logic [2:0] CFG_Y_SCALE  = 3'd5;
    localparam logic [2:0] CFG_STEPS    = 3'd6;

    localparam logic [STEP_W-1:0] STEPS_RESET = 7'd25;

    localparam logic [1:0] DIFF_NONE = 2'd0;
    localparam logic [1:0] DIFF_X    = 2'd1;
    localparam logic [1:0] DIFF_Y    = 2'd2;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_DX   = 3'd1;
    localparam logic [2:0] MUL_DY   = 3'd2;
    localparam logic [2:0] MUL_RR   = 3'd3;
    localparam logic [2:0] MUL_II   = 3'd4;
    localparam logic [2:0] MUL_RI   = 3'd5;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_X    = 3'd1;
    localparam logic [2:0] WR_Y    = 3'd2;
    localparam logic [2:0] WR_Z    = 3'd3;
    localparam logic [2:0] WR_OLD  = 3'd4;

    localparam logic JMP_NEXT = 1'b0;
    localparam logic JMP_EMIT = 1'b1;

    localparam logic [PC_W-1:0] PC_LOOP = 4'd4;

    typedef struct packed {
        logic [1:0]      diff;
        logic [2:0]      mul;
        logic [1:0]      acc;
        logic [2:0]      wr;
        logic            jmp;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic        outside;
        logic [15:0] from_x;
        logic [15:0] from_y;
        logic [15:0] to_x;
        logic [15:0] to_y;
    } t_dp_stat;

    typedef struct packed {
        logic emit;
        logic last;
    } t_emit;

    localparam t_ctrl CTRL_NOP = '{DIFF_NONE, MUL_NONE, ACC_NONE, WR_NONE, JMP_NEXT, '0};

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        case (pc)
            4'd0:  w.diff = DIFF_X;
            4'd1:  begin w.mul = MUL_DX; w.diff = DIFF_Y; end
            4'd2:  begin w.mul = MUL_DY; w.wr = WR_X; end
            4'd3:  w.wr = WR_Y;
            4'd4:  begin w.mul = MUL_RR; w.wr = WR_OLD; end
            4'd5:  begin w.mul = MUL_II; w.acc = ACC_LOAD; end
            4'd6:  begin w.mul = MUL_RI; w.acc = ACC_SUB; end
            4'd7:  w.wr = WR_Z;
            4'd8:  w.diff = DIFF_X;
            4'd9:  begin w.mul = MUL_DX; w.diff = DIFF_Y; end
            4'd10: begin w.mul = MUL_DY; w.wr = WR_X; end
            4'd11: w.wr = WR_Y;
            4'd12: begin w.jmp = JMP_EMIT; w.target = PC_LOOP; end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [41:0] v);
        logic [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [PIX_W-1:0] v);
        logic [15:0] r;
        if (v > PIX_W'(32767)) begin
            r = 16'h7FFF;
        end else if (v < -PIX_W'(32768)) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/qost_in_if.sv =====
interface qost_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_re;
    logic [31:0] point_im;
    logic        plot_mode;

    modport source (output valid, point_re, point_im, plot_mode, input ready);
    modport sink (input valid, point_re, point_im, plot_mode, output ready);
endinterface

// ===== rtl/qost_out_if.sv =====
interface qost_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] from_x;
    logic [15:0] from_y;
    logic [15:0] to_x;
    logic [15:0] to_y;
    logic        last_segment;

    modport source (output valid, from_x, from_y, to_x, to_y, last_segment, input ready);
    modport sink (input valid, from_x, from_y, to_x, to_y, last_segment, output ready);
endinterface

// ===== rtl/quadratic_orbit_segment_tracer.sv =====
// Traces the orbit of z -> z*z + c for one complex point per input beat and
// sends one line segment per orbit step on the output channel.
// The input channel carries point_re, point_im and plot_mode; the output channel
// carries from_x, from_y, to_x, to_y and last_segment, which marks the final
// segment of a point's trace. The user must write registers through the plain
// write port only while the block is idle; the block itself does not enforce this.
// A small microcode program drives one shared 33 by 33 multiplier: its first
// steps map the start point to pixels, and each orbit step then squares z, adds
// c, maps the new z to pixels and waits at the emit step to hand the segment to
// the output register.
// One point is traced at a time: the input is ready only while the block is
// idle, and a point whose step limit is zero produces no segment.
// When the receiver stalls, the finished segment waits in the output register
// and the sequencer holds at its emit step until the register frees up.
// Synchronous reset returns the sequencer to idle, drops the output valid and
// loads the register defaults, with a step limit of 25.
module quadratic_orbit_segment_tracer import qost_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qost_in_if.sink     i_pt,
    qost_out_if.source  o_seg,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic              busy, start, out_free;
    logic [STEP_W-1:0] steps;
    t_ctrl             ctrl;
    t_dp_stat          stat;
    t_emit             emit;

    logic        r_valid;
    logic [15:0] r_from_x, r_from_y, r_to_x, r_to_y;
    logic        r_last;

    assign i_pt.ready = !busy;
    assign start      = i_pt.valid && !busy;
    assign out_free   = !r_valid || o_seg.ready;

    qost_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_steps    (steps),
        .i_outside  (stat.outside),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl),
        .o_emit     (emit)
    );

    qost_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_load      (start),
        .i_point_re  (i_pt.point_re),
        .i_point_im  (i_pt.point_im),
        .i_plot_mode (i_pt.plot_mode),
        .i_ctrl      (ctrl),
        .o_steps     (steps),
        .o_stat      (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit.emit) begin
            r_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.emit) begin
            r_from_x <= stat.from_x;
            r_from_y <= stat.from_y;
            r_to_x   <= stat.to_x;
            r_to_y   <= stat.to_y;
            r_last   <= emit.last;
        end
    end

    assign o_seg.valid        = r_valid;
    assign o_seg.from_x       = r_from_x;
    assign o_seg.from_y       = r_from_y;
    assign o_seg.to_x         = r_to_x;
    assign o_seg.to_y         = r_to_y;
    assign o_seg.last_segment = r_last;

endmodule

// ===== rtl/qost_dp.sv =====
module qost_dp import qost_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_load,
    input  logic [31:0]        i_point_re,
    input  logic [31:0]        i_point_im,
    input  logic               i_plot_mode,
    input  t_ctrl              i_ctrl,
    output logic [STEP_W-1:0]  o_steps,
    output t_dp_stat           o_stat
);

    logic [31:0] r_const_re, r_const_im, r_left, r_top, r_x_scale, r_y_scale;
    logic [STEP_W-1:0] r_line_steps;

    logic signed [31:0] r_zre, r_zim, r_cre, r_cim;
    logic signed [32:0] r_diff;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [PIX_W-1:0] r_x, r_y, r_ox, r_oy;

    logic signed [32:0] mul_a, mul_b, n_diff;
    logic signed [65:0] mul_p;
    logic signed [41:0] re_sum, im_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_re   <= '0;
            r_const_im   <= '0;
            r_left       <= '0;
            r_top        <= '0;
            r_x_scale    <= '0;
            r_y_scale    <= '0;
            r_line_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONST_RE: r_const_re   <= i_cfg_data;
                CFG_CONST_IM: r_const_im   <= i_cfg_data;
                CFG_LEFT:     r_left       <= i_cfg_data;
                CFG_TOP:      r_top        <= i_cfg_data;
                CFG_X_SCALE:  r_x_scale    <= i_cfg_data;
                CFG_Y_SCALE:  r_y_scale    <= i_cfg_data;
                CFG_STEPS:    r_line_steps <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_steps = (r_line_steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : r_line_steps;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.mul)
            MUL_DX: begin mul_a = r_diff; mul_b = $signed({1'b0, r_x_scale}); end
            MUL_DY: begin mul_a = r_diff; mul_b = $signed({1'b0, r_y_scale}); end
            MUL_RR: begin mul_a = 33'(r_zre); mul_b = 33'(r_zre); end
            MUL_II: begin mul_a = 33'(r_zim); mul_b = 33'(r_zim); end
            MUL_RI: begin mul_a = 33'(r_zre); mul_b = 33'(r_zim); end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (i_ctrl.diff)
            DIFF_X:  n_diff = 33'(r_zre) - 33'($signed(r_left));
            DIFF_Y:  n_diff = 33'($signed(r_top)) - 33'(r_zim);
            default: n_diff = r_diff;
        endcase
    end

    assign re_sum = 42'($signed(r_acc[63:24])) + 42'(r_cre);
    assign im_sum = 42'($signed(r_prod[63:23])) + 42'(r_cim);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_plot_mode) begin
                r_zre <= i_point_re;
                r_zim <= i_point_im;
                r_cre <= r_const_re;
                r_cim <= r_const_im;
            end else begin
                r_zre <= r_const_re;
                r_zim <= r_const_im;
                r_cre <= i_point_re;
                r_cim <= i_point_im;
            end
        end else if (i_ctrl.wr == WR_Z) begin
            r_zre <= sat32(re_sum);
            r_zim <= sat32(im_sum);
        end
        r_diff <= n_diff;
        if (i_ctrl.mul != MUL_NONE) begin
            r_prod <= mul_p;
        end
        case (i_ctrl.acc)
            ACC_LOAD: r_acc <= r_prod[63:0];
            ACC_SUB:  r_acc <= r_acc - r_prod[63:0];
            default: ;
        endcase
        case (i_ctrl.wr)
            WR_X:   r_x <= r_prod[65:40];
            WR_Y:   r_y <= r_prod[65:40];
            WR_OLD: begin r_ox <= r_x; r_oy <= r_y; end
            default: ;
        endcase
    end

    assign o_stat.outside = (r_x >= PIX_W'(2 * IMG_W)) || (r_x < -PIX_W'(IMG_W))
                         || (r_y >= PIX_W'(2 * IMG_H)) || (r_y < -PIX_W'(IMG_H));
    assign o_stat.from_x = sat16(r_ox);
    assign o_stat.from_y = sat16(r_oy);
    assign o_stat.to_x   = sat16(r_x);
    assign o_stat.to_y   = sat16(r_y);

endmodule

// ===== rtl/qost_seq.sv =====
module qost_seq import qost_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_steps,
    input  logic              i_outside,
    input  logic              i_out_free,
    output logic              o_busy,
    output t_ctrl             o_ctrl,
    output t_emit             o_emit
);

    logic              r_busy, n_busy;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [STEP_W-1:0] r_cnt, n_cnt, r_steps, n_steps;
    t_ctrl             word;

    assign word = ucode(r_pc);
    assign o_busy = r_busy;
    assign o_ctrl = r_busy ? word : CTRL_NOP;
    assign o_emit.emit = r_busy && (word.jmp == JMP_EMIT) && i_out_free;
    assign o_emit.last = i_outside || ((r_cnt + 7'd1) == r_steps);

    always_comb begin
        n_busy  = r_busy;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_steps = r_steps;
        if (!r_busy) begin
            if (i_start && (i_steps != '0)) begin
                n_busy  = 1'b1;
                n_pc    = '0;
                n_cnt   = '0;
                n_steps = i_steps;
            end
        end else if (word.jmp == JMP_EMIT) begin
            if (i_out_free) begin
                if (o_emit.last) begin
                    n_busy = 1'b0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                    n_pc  = word.target;
                end
            end
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_steps <= '0;
        end else begin
            r_busy  <= n_busy;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_steps <= n_steps;
        end
    end

endmodule

// ===== test/quadratic_orbit_segment_tracer_tb.sv =====
module quadratic_orbit_segment_tracer_tb import qost_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          Q_ONE       = 1 << 24;
    localparam int unsigned VIEW_SCALE  = 32'd22369621;
    localparam int          IDLE_PAUSE  = 20;
    localparam int          TAIL_CYCLES = 600;
    localparam int          HOLD_CYCLES = 400;
    localparam longint      I32_MAX     = 64'sd2147483647;
    localparam longint      I32_MIN     = -64'sd2147483648;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;

    typedef enum logic {
        PARAM_PLANE   = 1'b0,
        DYNAMIC_PLANE = 1'b1
    } plot_mode_e;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_e;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        plot_mode_e  mode;
    } point_t;

    typedef struct packed {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] tx;
        logic [15:0] ty;
        logic        last;
    } segment_t;

    class orbit_scoreboard;
        logic signed [31:0] c_re, c_im, win_left, win_top;
        logic [31:0]        x_scale, y_scale;
        logic [6:0]         steps;
        segment_t           segs_due[$];
        int unsigned        mismatches;

        function new();
            c_re = '0;
            c_im = '0;
            win_left = '0;
            win_top = '0;
            x_scale = '0;
            y_scale = '0;
            steps = STEPS_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_CONST_RE: c_re = v;
                CFG_CONST_IM: c_im = v;
                CFG_LEFT:     win_left = v;
                CFG_TOP:      win_top = v;
                CFG_X_SCALE:  x_scale = v;
                CFG_Y_SCALE:  y_scale = v;
                CFG_STEPS:    steps = v[6:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return segs_due.size();
        endfunction

        function longint clamp32(longint v);
            if (v > I32_MAX) return I32_MAX;
            if (v < I32_MIN) return I32_MIN;
            return v;
        endfunction

        function logic [15:0] pix16(longint v);
            if (v > 32767) return 16'h7FFF;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function longint pixel_of(longint diff, logic [31:0] scale);
            logic [63:0] mag, prod, q;
            mag = (diff < 0) ? 64'(-diff) : 64'(diff);
            prod = mag * {32'd0, scale};
            q = prod >> 40;
            if (diff < 0) begin
                if (prod[39:0] != '0) q = q + 64'd1;
                return -longint'(q);
            end
            return longint'(q);
        endfunction

        function void note_point(point_t p);
            longint zr, zi, cr, ci, nr, ni, x, y, ox, oy;
            int n;
            bit outside;
            segment_t s;
            if (p.mode == DYNAMIC_PLANE) begin
                zr = longint'($signed(p.re));
                zi = longint'($signed(p.im));
                cr = longint'(c_re);
                ci = longint'(c_im);
            end else begin
                zr = longint'(c_re);
                zi = longint'(c_im);
                cr = longint'($signed(p.re));
                ci = longint'($signed(p.im));
            end
            n = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
            x = pixel_of(zr - longint'(win_left), x_scale);
            y = pixel_of(longint'(win_top) - zi, y_scale);
            for (int i = 0; i < n; i++) begin
                ox = x;
                oy = y;
                nr = clamp32(((zr * zr - zi * zi) >>> 24) + cr);
                ni = clamp32(((zr * zi) >>> 23) + ci);
                zr = nr;
                zi = ni;
                x = pixel_of(zr - longint'(win_left), x_scale);
                y = pixel_of(longint'(win_top) - zi, y_scale);
                outside = (x >= 2 * IMG_W) || (y >= 2 * IMG_H) || (x < -IMG_W) || (y < -IMG_H);
                s.fx = pix16(ox);
                s.fy = pix16(oy);
                s.tx = pix16(x);
                s.ty = pix16(y);
                s.last = outside || (i + 1 == n);
                segs_due.push_back(s);
                if (outside) break;
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t e;
            if (segs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected segment (%0d,%0d)->(%0d,%0d) last=%0b",
                             $signed(got.fx), $signed(got.fy), $signed(got.tx),
                             $signed(got.ty), got.last);
                return;
            end
            e = segs_due.pop_front();
            if (got.fx !== e.fx || got.fy !== e.fy || got.tx !== e.tx ||
                got.ty !== e.ty || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("segment mismatch: expected (%0d,%0d)->(%0d,%0d) last=%0b,",
                             $signed(e.fx), $signed(e.fy), $signed(e.tx), $signed(e.ty),
                             e.last,
                             " got (%0d,%0d)->(%0d,%0d) last=%0b",
                             $signed(got.fx), $signed(got.fy), $signed(got.tx),
                             $signed(got.ty), got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    bit          hold_req;

    qost_in_if  pt_if();
    qost_out_if seg_if();

    orbit_scoreboard sb = new();
    point_t          pts[$];

    quadratic_orbit_segment_tracer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .o_seg      (seg_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pt_if.valid && pt_if.ready)
            sb.note_point('{re: pt_if.point_re, im: pt_if.point_im,
                            mode: plot_mode_e'(pt_if.plot_mode)});
    end

    // One segment per output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && seg_if.valid && seg_if.ready)
            sb.check_segment('{fx: seg_if.from_x, fy: seg_if.from_y, tx: seg_if.to_x,
                               ty: seg_if.to_y, last: seg_if.last_segment});
    end

    initial begin
        rx_mode_e    rx_mode;
        int unsigned rx_left;
        int unsigned rx_tick;
        rx_mode = RX_OPEN;
        rx_left = 0;
        rx_tick = 0;
        seg_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                seg_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   seg_if.ready <= 1'b1;
                RX_COIN:   seg_if.ready <= $urandom_range(0, 1);
                RX_SPARSE: seg_if.ready <= ($urandom_range(0, 3) == 0);
                default:   seg_if.ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    function automatic point_t mk_point(int re, int im, plot_mode_e m);
        point_t p;
        p.re = re;
        p.im = im;
        p.mode = m;
        return p;
    endfunction

    function automatic point_t rand_point();
        point_t p;
        if ($urandom_range(0, 99) < 85) begin
            p.re = int'($urandom_range(0, 11 * Q_ONE / 4)) - 2 * Q_ONE;
            p.im = int'($urandom_range(0, 5 * Q_ONE / 2)) - 5 * Q_ONE / 4;
        end else begin
            p.re = $urandom();
            p.im = $urandom();
        end
        p.mode = plot_mode_e'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic write_view(input int c_re, input int c_im, input logic [6:0] steps);
        write_reg(CFG_CONST_RE, c_re);
        write_reg(CFG_CONST_IM, c_im);
        write_reg(CFG_LEFT, -2 * Q_ONE);
        write_reg(CFG_TOP, 3 * Q_ONE / 2);
        write_reg(CFG_X_SCALE, VIEW_SCALE);
        write_reg(CFG_Y_SCALE, VIEW_SCALE);
        write_reg(CFG_STEPS, 32'(steps));
    endtask

    task automatic rand_config(input bit wild);
        if (wild) begin
            write_reg(CFG_CONST_RE, $urandom());
            write_reg(CFG_CONST_IM, $urandom());
            write_reg(CFG_LEFT, $urandom());
            write_reg(CFG_TOP, $urandom());
            write_reg(CFG_X_SCALE, $urandom());
            write_reg(CFG_Y_SCALE, $urandom());
            write_reg(CFG_STEPS, $urandom_range(0, 127));
        end else begin
            write_reg(CFG_CONST_RE, int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
            write_reg(CFG_CONST_IM, int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
            write_reg(CFG_LEFT, -2 * Q_ONE + int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4);
            write_reg(CFG_TOP, 3 * Q_ONE / 2 + int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4);
            write_reg(CFG_X_SCALE, $urandom_range(VIEW_SCALE / 2, VIEW_SCALE * 2));
            write_reg(CFG_Y_SCALE, $urandom_range(VIEW_SCALE / 2, VIEW_SCALE * 2));
            write_reg(CFG_STEPS, ($urandom_range(0, 7) == 0) ? MAX_STEPS
                                                               : $urandom_range(1, 40));
        end
    endtask

    task automatic drive_points();
        point_t      p;
        int unsigned burst;
        int unsigned gap;
        while (pts.size() > 0) begin
            burst = $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0:       gap = 0;
                1:       gap = $urandom_range(13, 40);
                default: gap = $urandom_range(1, 12);
            endcase
            @(posedge i_clk);
            repeat (gap) @(posedge i_clk);
            while (burst > 0 && pts.size() > 0) begin
                p = pts.pop_front();
                pt_if.valid <= 1'b1;
                pt_if.point_re <= p.re;
                pt_if.point_im <= p.im;
                pt_if.plot_mode <= p.mode;
                do @(posedge i_clk); while (!pt_if.ready);
                burst--;
            end
            pt_if.valid <= 1'b0;
        end
    endtask

    // The extra edge lets the last accepted point reach the scoreboard first.
    task automatic settle();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    initial begin
        point_t p;
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        pt_if.valid <= 1'b0;
        pt_if.point_re <= '0;
        pt_if.point_im <= '0;
        pt_if.plot_mode <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pts.push_back(mk_point(0, 0, PARAM_PLANE));
        pts.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, PARAM_PLANE));
        pts.push_back(mk_point(32'h8000_0000, 32'h8000_0000, DYNAMIC_PLANE));
        pts.push_back(mk_point(-1, 1, DYNAMIC_PLANE));
        drive_points();
        settle();

        write_view(-13421773, 2617245, 7'd25);
        pts.push_back(mk_point(0, 0, PARAM_PLANE));
        pts.push_back(mk_point(-Q_ONE, 0, PARAM_PLANE));
        pts.push_back(mk_point(2 * Q_ONE, 0, PARAM_PLANE));
        pts.push_back(mk_point(-2 * Q_ONE, 0, PARAM_PLANE));
        pts.push_back(mk_point(Q_ONE / 4, Q_ONE / 2, DYNAMIC_PLANE));
        pts.push_back(mk_point(0, 0, DYNAMIC_PLANE));
        drive_points();
        settle();

        write_reg(CFG_CONST_RE, 32'h7FFF_FFFF);
        write_reg(CFG_CONST_IM, 32'h8000_0000);
        write_reg(CFG_LEFT, 32'h8000_0000);
        write_reg(CFG_TOP, 32'h7FFF_FFFF);
        write_reg(CFG_X_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_Y_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_STEPS, MAX_STEPS);
        pts.push_back(mk_point(0, 0, PARAM_PLANE));
        pts.push_back(mk_point(0, 0, DYNAMIC_PLANE));
        pts.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, PARAM_PLANE));
        pts.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, DYNAMIC_PLANE));
        drive_points();
        settle();

        write_reg(CFG_LEFT, 32'h7FFF_FFFF);
        write_reg(CFG_TOP, 32'h8000_0000);
        write_reg(CFG_X_SCALE, 32'd1);
        write_reg(CFG_Y_SCALE, 32'd1);
        write_reg(CFG_STEPS, 32'd1);
        pts.push_back(mk_point(Q_ONE, -Q_ONE, PARAM_PLANE));
        pts.push_back(mk_point(-Q_ONE, Q_ONE, DYNAMIC_PLANE));
        drive_points();
        settle();

        write_reg(CFG_STEPS, 32'd0);
        write_reg(CFG_UNUSED, $urandom());
        pts.push_back(mk_point(0, 0, PARAM_PLANE));
        pts.push_back(mk_point(Q_ONE, Q_ONE, DYNAMIC_PLANE));
        pts.push_back(rand_point());
        drive_points();
        settle();

        write_view(Q_ONE / 10, Q_ONE / 10, 7'd127);
        hold_req = 1'b1;
        pts.push_back(mk_point(0, 0, DYNAMIC_PLANE));
        pts.push_back(mk_point(Q_ONE / 8, -Q_ONE / 8, DYNAMIC_PLANE));
        pts.push_back(mk_point(-Q_ONE / 8, Q_ONE / 8, PARAM_PLANE));
        for (int i = 0; i < 6; i++) begin
            p = rand_point();
            if (i < 4) begin
                p.re = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
                p.im = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
            end
            pts.push_back(p);
        end
        drive_points();
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            rand_config(ph == 3);
            for (int i = 0; i < 18; i++) pts.push_back(rand_point());
            drive_points();
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== quadratic_orbit_segment_tracer.f =====
rtl/qost_pkg.sv
rtl/qost_in_if.sv
rtl/qost_out_if.sv
rtl/qost_dp.sv
rtl/qost_seq.sv
rtl/quadratic_orbit_segment_tracer.sv
test/quadratic_orbit_segment_tracer_tb.sv
